// ===== rtl/drpts_pkg.sv =====
// Shared types and constants of the DAC ramp pin threshold sweep unit.
package drpts_pkg;

    localparam int PIN_W      = 7;   // width of a pin index
    localparam int RAMP_W     = 12;  // width of the ramp registers
    localparam int RIDX_W     = 13;  // width of the running ramp index
    localparam int COUNT_W    = 10;  // width of reading and vote counts
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_RAMP_MIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_MAX       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_READS_PER_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_DOWNWARD  = 3'd4;

    localparam logic [RAMP_W-1:0]  RAMP_MIN_RST       = 12'd0;
    localparam logic [RAMP_W-1:0]  RAMP_MAX_RST       = 12'd4095;
    localparam logic [RAMP_W-1:0]  RAMP_STEP_RST      = 12'd1;
    localparam logic [COUNT_W-1:0] READS_PER_STEP_RST = 10'd10;
    localparam logic               RAMP_DOWNWARD_RST  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_PIN   = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    typedef enum logic [1:0]
    {
        CMD_START_ALL = 2'd0,
        CMD_START_ONE = 2'd1,
        CMD_SAMPLE    = 2'd2,
        CMD_READ      = 2'd3
    } cmd_t;

    typedef enum logic [1:0]
    {
        MODE_IDLE = 2'd0,
        MODE_ALL  = 2'd1,
        MODE_ONE  = 2'd2
    } mode_t;

    typedef struct packed
    {
        logic [RAMP_W-1:0]  ramp_min;
        logic [RAMP_W-1:0]  ramp_max;
        logic [RAMP_W-1:0]  ramp_step;
        logic [COUNT_W-1:0] reads_per_step;
        logic               ramp_downward;
    } cfg_t;

    // Per-lane update strobes, already qualified by an accepted beat.
    typedef struct packed
    {
        logic clear;       // new sweep: forget the result, latch the reference
        logic vote;        // sample beat that this lane takes part in
        logic drop_votes;  // ramp moves on: zero the vote count
    } lane_ctl_t;

    // Strobes from the sequencer that are common to every lane.
    typedef struct packed
    {
        logic start_all;
        logic start_one;
        logic vote_live;
        logic vote_all;
        logic drop_votes;
    } seq_ctl_t;

    // What the merge stage needs to know about an accepted beat.
    typedef struct packed
    {
        logic [PIN_W-1:0] report_pin;
        logic [1:0]       status;
        logic             sweep_end;
        logic             busy;
    } meta_t;

endpackage

// ===== rtl/drpts_lane.sv =====
// One pin's threshold detector: reference level, vote count and recorded flip code.
module drpts_lane
    import drpts_pkg::*;
#(
    parameter int DAC_BITS = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lane_ctl_t            ctl,
    input  logic                 level,
    input  logic [COUNT_W-2:0]   vote_half,
    input  logic [DAC_BITS-1:0]  vote_code,
    output logic                 hit,
    output logic                 done,
    output logic [DAC_BITS-1:0]  code
);

    logic                done_reg, done_next;
    logic [DAC_BITS-1:0] code_reg, code_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                ref_reg, ref_next;
    logic [COUNT_W-1:0]  count_inc;

    assign count_inc = count_reg + COUNT_W'(level != ref_reg);
    assign hit       = ctl.vote && !done_reg && (count_inc > {1'b0, vote_half});

    always_comb
    begin
        done_next  = done_reg;
        code_next  = code_reg;
        count_next = count_reg;
        ref_next   = ref_reg;
        if (ctl.clear)
        begin
            done_next  = 1'b0;
            code_next  = '0;
            count_next = '0;
            ref_next   = level;
        end
        else
        begin
            if (ctl.vote && !done_reg)
            begin
                count_next = count_inc;
            end
            if (hit)
            begin
                done_next = 1'b1;
                code_next = vote_code;
            end
            if (ctl.drop_votes)
            begin
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            code_reg  <= '0;
            count_reg <= '0;
            ref_reg   <= 1'b0;
        end
        else
        begin
            done_reg  <= done_next;
            code_reg  <= code_next;
            count_reg <= count_next;
            ref_reg   <= ref_next;
        end
    end

    assign done = done_reg;
    assign code = code_reg;

endmodule

// ===== rtl/drpts_ctrl.sv =====
// Sweep sequencer: sweep mode, ramp index, reading count and per-beat result fields.
module drpts_ctrl
    import drpts_pkg::*;
#(
    parameter int NUM_PINS = 80,
    parameter int DAC_BITS = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [1:0]           command,
    input  logic [PIN_W-1:0]     pin_index,
    input  cfg_t                 cfg,
    input  logic                 single_found,
    output seq_ctl_t             seq,
    output logic [PIN_W-1:0]     single_pin,
    output logic [DAC_BITS-1:0]  vote_code,
    output meta_t                meta_next,
    output logic [DAC_BITS-1:0]  dac_code_next
);

    localparam int CW = (DAC_BITS > RIDX_W) ? DAC_BITS : RIDX_W;

    mode_t              mode_reg, mode_next;
    logic [RIDX_W-1:0]  ridx_reg, ridx_next;
    logic [COUNT_W-1:0] rcount_reg, rcount_next;
    logic [PIN_W-1:0]   spin_reg, spin_next;

    logic               pin_ok;
    logic               start_all, start_one, start_any, start_bad, read_bad;
    logic               empty_range, sample_live, rps_zero, one_found;
    logic               step_done, ramp_over, single_item, sweep_end;
    logic [COUNT_W-1:0] rcount_inc;
    logic [RIDX_W-1:0]  ridx_step;

    function automatic logic [DAC_BITS-1:0] code_of(input logic [RIDX_W-1:0] ridx,
                                                    input logic [RAMP_W-1:0] rmax,
                                                    input logic down);
        logic [CW-1:0] wide;
        if (down)
        begin
            wide = CW'(rmax) - CW'(ridx);
        end
        else
        begin
            wide = CW'(ridx);
        end
        return wide[DAC_BITS-1:0];
    endfunction

    assign pin_ok      = {1'b0, pin_index} < (PIN_W + 1)'(NUM_PINS);
    assign start_all   = accept && (command == CMD_START_ALL);
    assign start_one   = accept && (command == CMD_START_ONE) && pin_ok;
    assign start_bad   = accept && (command == CMD_START_ONE) && !pin_ok;
    assign read_bad    = accept && (command == CMD_READ) && !pin_ok;
    assign start_any   = start_all || start_one;
    assign empty_range = cfg.ramp_min >= cfg.ramp_max;
    assign sample_live = accept && (command == CMD_SAMPLE) && (mode_reg != MODE_IDLE);
    assign rps_zero    = (cfg.reads_per_step == '0);
    assign rcount_inc  = rps_zero ? rcount_reg : rcount_reg + COUNT_W'(1);
    assign one_found   = (mode_reg == MODE_ONE) && single_found;
    assign step_done   = sample_live && !one_found && (rcount_inc >= cfg.reads_per_step);
    assign ridx_step   = ridx_reg + {1'b0, cfg.ramp_step};
    assign ramp_over   = ridx_step >= {1'b0, cfg.ramp_max};

    // Next state of the sequencer
    always_comb
    begin
        mode_next   = mode_reg;
        ridx_next   = ridx_reg;
        rcount_next = rcount_reg;
        spin_next   = spin_reg;
        if (start_any)
        begin
            if (start_one)
            begin
                spin_next = pin_index;
            end
            ridx_next   = {1'b0, cfg.ramp_min};
            rcount_next = '0;
            if (empty_range)
            begin
                mode_next = MODE_IDLE;
            end
            else if (start_one)
            begin
                mode_next = MODE_ONE;
            end
            else
            begin
                mode_next = MODE_ALL;
            end
        end
        else if (sample_live)
        begin
            if (one_found)
            begin
                mode_next   = MODE_IDLE;
                rcount_next = rcount_inc;
            end
            else if (step_done)
            begin
                rcount_next = '0;
                ridx_next   = ridx_step;
                if (ramp_over)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            else
            begin
                rcount_next = rcount_inc;
            end
        end
    end

    // Outputs of the sequencer
    always_comb
    begin
        seq.start_all  = start_all;
        seq.start_one  = start_one;
        seq.vote_live  = sample_live && !rps_zero;
        seq.vote_all   = (mode_reg == MODE_ALL);
        seq.drop_votes = step_done;

        sweep_end = (start_any && empty_range) || (sample_live && one_found)
                    || (step_done && ramp_over);

        if (start_bad || read_bad)
        begin
            meta_next.status = STATUS_BAD_PIN;
        end
        else if ((start_one && empty_range)
                 || (step_done && ramp_over && (mode_reg == MODE_ONE)))
        begin
            meta_next.status = STATUS_NOT_FOUND;
        end
        else
        begin
            meta_next.status = STATUS_OK;
        end

        case (command)
            CMD_START_ALL: single_item = 1'b0;
            CMD_START_ONE: single_item = pin_ok || (mode_reg == MODE_ONE);
            CMD_READ:      single_item = 1'b0;
            default:       single_item = (mode_reg == MODE_ONE);
        endcase

        meta_next.report_pin = single_item ? spin_next : pin_index;
        meta_next.sweep_end  = sweep_end;
        meta_next.busy       = (mode_next != MODE_IDLE);

        if (mode_next != MODE_IDLE)
        begin
            dac_code_next = code_of(ridx_next, cfg.ramp_max, cfg.ramp_downward);
        end
        else
        begin
            dac_code_next = cfg.ramp_downward ? '1 : '0;
        end
    end

    assign single_pin = spin_reg;
    assign vote_code  = code_of(ridx_reg, cfg.ramp_max, cfg.ramp_downward);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            ridx_reg   <= '0;
            rcount_reg <= '0;
            spin_reg   <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            ridx_reg   <= ridx_next;
            rcount_reg <= rcount_next;
            spin_reg   <= spin_next;
        end
    end

    a_single_pin_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_ONE) |-> ({1'b0, spin_reg} < (PIN_W + 1)'(NUM_PINS)))
        else $error("single sweep running on a pin outside the array");

    a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sweep_end) |=> (mode_reg == MODE_IDLE))
        else $error("sweep reported finished but the sequencer is still running");

    a_ramp_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(ridx_reg) && $stable(rcount_reg)))
        else $error("ramp state moved without an accepted beat");

endmodule

// ===== rtl/drpts_merge.sv =====
// Merge stage: picks the reported pin's result from the lanes and holds the result beat.
module drpts_merge
    import drpts_pkg::*;
#(
    parameter int NUM_PINS = 80,
    parameter int DAC_BITS = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  meta_t                meta_next,
    input  logic [DAC_BITS-1:0]  dac_code_next,
    input  logic [NUM_PINS-1:0]  lane_done,
    input  logic [DAC_BITS-1:0]  lane_code [NUM_PINS],
    input  logic                 res_stall,
    output logic                 item_stall,
    output logic                 res_valid,
    output logic [DAC_BITS-1:0]  dac_code,
    output logic                 busy_res,
    output logic                 sweep_end,
    output logic                 pin_found,
    output logic [DAC_BITS-1:0]  pin_code,
    output logic [1:0]           status
);

    localparam int IDX_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

    logic                s1_valid_reg, s1_valid_next;
    meta_t               s1_meta_reg;
    logic [DAC_BITS-1:0] s1_dac_reg;
    logic                out_valid_reg, out_valid_next;
    logic [DAC_BITS-1:0] dac_code_reg;
    logic                busy_reg, end_reg, found_reg;
    logic [DAC_BITS-1:0] pin_code_reg;
    logic [1:0]          status_reg;

    logic                s1_advance, rp_ok;
    logic [IDX_W-1:0]    rp_idx;
    logic                found_sel;
    logic [DAC_BITS-1:0] code_sel;

    // Stage one advances whenever the result register is free or being emptied.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !res_stall);
    assign item_stall = s1_valid_reg && out_valid_reg && res_stall;

    assign rp_ok  = ({1'b0, s1_meta_reg.report_pin} < (PIN_W + 1)'(NUM_PINS))
                    && (s1_meta_reg.status != STATUS_BAD_PIN);
    assign rp_idx = s1_meta_reg.report_pin[IDX_W-1:0];

    always_comb
    begin
        found_sel = 1'b0;
        code_sel  = '0;
        if (rp_ok)
        begin
            found_sel = lane_done[rp_idx];
            code_sel  = lane_code[rp_idx];
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg <= meta_next;
            s1_dac_reg  <= dac_code_next;
        end
        if (s1_advance)
        begin
            dac_code_reg <= s1_dac_reg;
            busy_reg     <= s1_meta_reg.busy;
            end_reg      <= s1_meta_reg.sweep_end;
            found_reg    <= found_sel;
            pin_code_reg <= code_sel;
            status_reg   <= s1_meta_reg.status;
        end
    end

    assign res_valid = out_valid_reg;
    assign dac_code  = dac_code_reg;
    assign busy_res  = busy_reg;
    assign sweep_end = end_reg;
    assign pin_found = found_reg;
    assign pin_code  = pin_code_reg;
    assign status    = status_reg;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!s1_valid_reg || s1_advance))
        else $error("beat accepted over a stage that could not move on");

    a_found_needs_good_pin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> (status_reg != STATUS_BAD_PIN))
        else $error("pin reported found with an out-of-range index");

    a_end_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && end_reg) |-> !busy_reg)
        else $error("finished sweep still reported as running");

endmodule

// ===== rtl/dac_ramp_pin_threshold_sweep_unit.sv =====
// Top level of the DAC ramp pin threshold sweep unit: config registers, pin lanes and merge.
// Latency: two register stages, merge stage one and the result register; a result beat is
//   presented once its item beat has passed through both of them.
// Throughput: one item per cycle unless res_stall holds a full result register; every pin
//   lane updates in the same cycle; the merge reads the registered lane state from stage one.
// Reset (rst_n, asynchronous): sweep idle, all pin results, votes and references zero,
//   registers at ramp_min 0, ramp_max 4095, ramp_step 1, reads_per_step 10, downward.
module dac_ramp_pin_threshold_sweep_unit
    import drpts_pkg::*;
#(
    parameter int NUM_PINS  = 80,
    parameter int BANK_PINS = 40,
    parameter int DAC_BITS  = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [1:0]            command,
    input  logic [PIN_W-1:0]      pin_index,
    input  logic [BANK_PINS-1:0]  levels_low,
    input  logic [BANK_PINS-1:0]  levels_high,

    output logic                  res_valid,
    input  logic                  res_stall,
    output logic [DAC_BITS-1:0]   dac_code,
    output logic                  busy_res,
    output logic                  sweep_end,
    output logic                  pin_found,
    output logic [DAC_BITS-1:0]   pin_code,
    output logic [1:0]            status
);

    cfg_t                cfg_reg, cfg_next;
    logic                accept;
    seq_ctl_t            seq;
    logic [PIN_W-1:0]    single_pin;
    logic [DAC_BITS-1:0] vote_code;
    meta_t               meta_next;
    logic [DAC_BITS-1:0] dac_code_next;

    logic [NUM_PINS-1:0] level;
    logic [NUM_PINS-1:0] lane_hit;
    logic [NUM_PINS-1:0] lane_single;
    logic [NUM_PINS-1:0] lane_done;
    logic [DAC_BITS-1:0] lane_code [NUM_PINS];
    logic                single_found;

    assign accept = item_valid && !item_stall;

    // Configuration registers: take the low bits of the write data.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_RAMP_MIN:       cfg_next.ramp_min       = cfg_data[RAMP_W-1:0];
                REG_RAMP_MAX:       cfg_next.ramp_max       = cfg_data[RAMP_W-1:0];
                REG_RAMP_STEP:      cfg_next.ramp_step      = cfg_data[RAMP_W-1:0];
                REG_READS_PER_STEP: cfg_next.reads_per_step = cfg_data[COUNT_W-1:0];
                REG_RAMP_DOWNWARD:  cfg_next.ramp_downward  = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ramp_min       <= RAMP_MIN_RST;
            cfg_reg.ramp_max       <= RAMP_MAX_RST;
            cfg_reg.ramp_step      <= RAMP_STEP_RST;
            cfg_reg.reads_per_step <= READS_PER_STEP_RST;
            cfg_reg.ramp_downward  <= RAMP_DOWNWARD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer: decides per beat what the lanes do and what the result reports.
    drpts_ctrl #(
        .NUM_PINS (NUM_PINS),
        .DAC_BITS (DAC_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .command       (command),
        .pin_index     (pin_index),
        .cfg           (cfg_reg),
        .single_found  (single_found),
        .seq           (seq),
        .single_pin    (single_pin),
        .vote_code     (vote_code),
        .meta_next     (meta_next),
        .dac_code_next (dac_code_next)
    );

    // One lane per pin. Pins past both banks always read low.
    for (genvar p = 0; p < NUM_PINS; p++)
    begin : g_lane
        lane_ctl_t ctl;

        if (p < BANK_PINS)
        begin : g_low
            assign level[p] = levels_low[p];
        end
        else if (p < 2 * BANK_PINS)
        begin : g_high
            assign level[p] = levels_high[p - BANK_PINS];
        end
        else
        begin : g_none
            assign level[p] = 1'b0;
        end

        assign lane_single[p] = (single_pin == PIN_W'(p));
        assign ctl.clear      = seq.start_all || (seq.start_one && (pin_index == PIN_W'(p)));
        assign ctl.vote       = seq.vote_live && (seq.vote_all || lane_single[p]);
        assign ctl.drop_votes = seq.drop_votes;

        drpts_lane #(
            .DAC_BITS (DAC_BITS)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .level     (level[p]),
            .vote_half (cfg_reg.reads_per_step[COUNT_W-1:1]),
            .vote_code (vote_code),
            .hit       (lane_hit[p]),
            .done      (lane_done[p]),
            .code      (lane_code[p])
        );
    end

    // In a single sweep only the chosen lane votes, so any hit on it ends the sweep.
    assign single_found = |(lane_hit & lane_single);

    // Merge: pick the reported pin after this beat's update and hold the result beat.
    drpts_merge #(
        .NUM_PINS (NUM_PINS),
        .DAC_BITS (DAC_BITS)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .meta_next     (meta_next),
        .dac_code_next (dac_code_next),
        .lane_done     (lane_done),
        .lane_code     (lane_code),
        .res_stall     (res_stall),
        .item_stall    (item_stall),
        .res_valid     (res_valid),
        .dac_code      (dac_code),
        .busy_res      (busy_res),
        .sweep_end     (sweep_end),
        .pin_found     (pin_found),
        .pin_code      (pin_code),
        .status        (status)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the DAC ramp pin threshold sweep unit.
`timescale 1ns / 100ps

module testbench;
    import drpts_pkg::*;

    localparam int NUM_PINS  = 80;
    localparam int BANK_PINS = 40;
    localparam int DAC_BITS  = 12;

    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 60;    // random items per phase, before the last sweep ends
    localparam int HOLD_AFTER   = 100;   // result beats seen before the long receiver hold-off
    localparam int HOLD_CYCLES  = 90;
    localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either channel
    localparam int SETTLE       = 8;     // cycles after the drain for stray beats to show
    localparam int MAX_SAMPLES  = 1100;

    // One result beat as the block should present it.
    typedef struct packed
    {
        logic [DAC_BITS-1:0] dac_code;
        logic                busy;
        logic                ended;
        logic                found;
        logic [DAC_BITS-1:0] code;
        logic [1:0]          status;
    } sweep_res_t;

    // One row of the directed table; typed rows carry their own expected beat.
    typedef struct
    {
        logic [1:0]       cmd;
        logic [PIN_W-1:0] pin;
        logic [39:0]      lo;
        logic [39:0]      hi;
        bit               typed;
        sweep_res_t       res;
    } dir_row_t;

    // Results that can be read straight off the behaviour at rest and at a sweep's first code.
    localparam sweep_res_t REST_OK  = '{12'hFFF, 1'b0, 1'b0, 1'b0, 12'h000, STATUS_OK};
    localparam sweep_res_t REST_BAD = '{12'hFFF, 1'b0, 1'b0, 1'b0, 12'h000, STATUS_BAD_PIN};
    localparam sweep_res_t FIRST_CODE = '{12'hFFF, 1'b1, 1'b0, 1'b0, 12'h000, STATUS_OK};

    // Register settings of the random phases: extremes, an empty range, zero step and
    // zero reads among them.
    logic [11:0] plan_min   [PHASES] = '{100, 0, 4000, 0, 4095, 10, 50, 200, 0};
    logic [11:0] plan_max   [PHASES] = '{104, 12, 4095, 4095, 0, 20, 51, 230, 6};
    logic [11:0] plan_step  [PHASES] = '{1, 4, 32, 4095, 1, 3, 1, 0, 1};
    logic [9:0]  plan_reads [PHASES] = '{3, 5, 2, 7, 4, 1, 1023, 3, 0};
    logic        plan_down  [PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0, 1};

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  item_valid  = 1'b0;
    logic                  item_stall;
    logic [1:0]            command     = '0;
    logic [PIN_W-1:0]      pin_index   = '0;
    logic [BANK_PINS-1:0]  levels_low  = '0;
    logic [BANK_PINS-1:0]  levels_high = '0;
    logic                  res_valid;
    logic                  res_stall   = 1'b0;
    logic [DAC_BITS-1:0]   dac_code;
    logic                  busy_res;
    logic                  sweep_end;
    logic                  pin_found;
    logic [DAC_BITS-1:0]   pin_code;
    logic [1:0]            status;

    // Predictor's own copy of the registers and of every pin lane.
    cfg_t            ramp_cfg = '{RAMP_MIN_RST, RAMP_MAX_RST, RAMP_STEP_RST,
                                  READS_PER_STEP_RST, RAMP_DOWNWARD_RST};
    bit              lane_done  [NUM_PINS];
    bit [11:0]       lane_code  [NUM_PINS];
    bit [9:0]        lane_votes [NUM_PINS];
    bit              lane_ref   [NUM_PINS];
    bit [RIDX_W-1:0] ramp_idx   = '0;
    bit [9:0]        reads_done = '0;
    mode_t           sweep_mode = MODE_IDLE;
    bit [PIN_W-1:0]  lone_pin   = '0;

    sweep_res_t pending_results [$];
    dir_row_t   plan [$];

    int          mismatches   = 0;
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned send_idle    = 0;
    int unsigned recv_idle    = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;
    int unsigned quiet_cycles = 0;

    dac_ramp_pin_threshold_sweep_unit #(
        .NUM_PINS  (NUM_PINS),
        .BANK_PINS (BANK_PINS),
        .DAC_BITS  (DAC_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .command     (command),
        .pin_index   (pin_index),
        .levels_low  (levels_low),
        .levels_high (levels_high),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .dac_code    (dac_code),
        .busy_res    (busy_res),
        .sweep_end   (sweep_end),
        .pin_found   (pin_found),
        .pin_code    (pin_code),
        .status      (status)
    );

    always #2 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    // Level of one pin in a reading; pins past both banks read low.
    function automatic bit pin_level(int p, logic [39:0] lo, logic [39:0] hi);
        if (p < BANK_PINS)
            return lo[p];
        if (p < 2 * BANK_PINS)
            return hi[p - BANK_PINS];
        return 1'b0;
    endfunction

    // Code the ramp drives at the present index; wraps at the DAC width.
    function automatic bit [11:0] ramp_code();
        bit [RIDX_W-1:0] diff;
        diff = {1'b0, ramp_cfg.ramp_max} - ramp_idx;
        return ramp_cfg.ramp_downward ? diff[11:0] : ramp_idx[11:0];
    endfunction

    // Forget a lane's result and latch its reference from the start beat.
    function automatic void clear_lane(int p, logic [39:0] lo, logic [39:0] hi);
        lane_done[p]  = 1'b0;
        lane_code[p]  = '0;
        lane_votes[p] = '0;
        lane_ref[p]   = pin_level(p, lo, hi);
    endfunction

    // Count a reading that differs from the reference; record the code on a majority.
    function automatic void vote_lane(int p, logic [39:0] lo, logic [39:0] hi);
        if (lane_done[p])
            return;
        if (pin_level(p, lo, hi) != lane_ref[p])
            lane_votes[p] = lane_votes[p] + 10'd1;
        if (lane_votes[p] > (ramp_cfg.reads_per_step >> 1))
        begin
            lane_done[p] = 1'b1;
            lane_code[p] = ramp_code();
        end
    endfunction

    // Advance the sweep by one accepted item beat and work out its result beat.
    function automatic sweep_res_t next_sweep_result(logic [1:0] cmd, logic [PIN_W-1:0] pin,
                                                     logic [39:0] lo, logic [39:0] hi);
        sweep_res_t r;
        bit         single;
        r      = '0;
        single = (sweep_mode == MODE_ONE);
        r.status = STATUS_OK;
        if (cmd == CMD_START_ALL || cmd == CMD_START_ONE)
        begin
            if (cmd == CMD_START_ONE && pin >= NUM_PINS)
                r.status = STATUS_BAD_PIN;
            else
            begin
                if (cmd == CMD_START_ALL)
                begin
                    for (int p = 0; p < NUM_PINS; p++)
                        clear_lane(p, lo, hi);
                    sweep_mode = MODE_ALL;
                    single     = 1'b0;
                end
                else
                begin
                    lone_pin = pin;
                    clear_lane(pin, lo, hi);
                    sweep_mode = MODE_ONE;
                    single     = 1'b1;
                end
                ramp_idx   = {1'b0, ramp_cfg.ramp_min};
                reads_done = '0;
                if (ramp_idx >= {1'b0, ramp_cfg.ramp_max})
                begin
                    r.ended    = 1'b1;
                    sweep_mode = MODE_IDLE;
                    if (single)
                        r.status = STATUS_NOT_FOUND;
                end
            end
        end
        else if (cmd == CMD_SAMPLE && sweep_mode != MODE_IDLE)
        begin
            if (ramp_cfg.reads_per_step != 0)
            begin
                if (sweep_mode == MODE_ALL)
                    for (int p = 0; p < NUM_PINS; p++)
                        vote_lane(p, lo, hi);
                else
                    vote_lane(lone_pin, lo, hi);
                reads_done = reads_done + 10'd1;
            end
            if (sweep_mode == MODE_ONE && lane_done[lone_pin])
            begin
                r.ended    = 1'b1;
                sweep_mode = MODE_IDLE;
            end
            else if (reads_done >= ramp_cfg.reads_per_step)
            begin
                reads_done = '0;
                for (int p = 0; p < NUM_PINS; p++)
                    lane_votes[p] = '0;
                ramp_idx = ramp_idx + {1'b0, ramp_cfg.ramp_step};
                if (ramp_idx >= {1'b0, ramp_cfg.ramp_max})
                begin
                    r.ended = 1'b1;
                    if (sweep_mode == MODE_ONE)
                        r.status = STATUS_NOT_FOUND;
                    sweep_mode = MODE_IDLE;
                end
            end
        end
        else if (cmd == CMD_READ)
        begin
            single = 1'b0;
            if (pin >= NUM_PINS)
                r.status = STATUS_BAD_PIN;
        end

        // A single sweep reports its own pin; everything else reports pin_index.
        if (single)
        begin
            if (r.status != STATUS_BAD_PIN && lone_pin < NUM_PINS)
            begin
                r.found = lane_done[lone_pin];
                r.code  = lane_code[lone_pin];
            end
        end
        else if (pin < NUM_PINS)
        begin
            r.found = lane_done[pin];
            r.code  = lane_code[pin];
        end

        if (sweep_mode != MODE_IDLE)
            r.dac_code = ramp_code();
        else
            r.dac_code = ramp_cfg.ramp_downward ? 12'hFFF : 12'h000;
        r.busy = (sweep_mode != MODE_IDLE);
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic logic [79:0] rand_levels();
        return 80'({$urandom(), $urandom(), $urandom()});
    endfunction

    // Mostly real pins, now and then an index past the end.
    function automatic logic [PIN_W-1:0] rand_pin();
        if ($urandom_range(0, 99) < 85)
            return PIN_W'($urandom_range(0, NUM_PINS - 1));
        return PIN_W'($urandom_range(NUM_PINS, 127));
    endfunction

    // Offer one item beat, hold it until taken, then queue what it should produce.
    // Valid stays high after the beat; the next call or the caller drops it.
    task automatic push_item(logic [1:0] cmd, logic [PIN_W-1:0] pin, logic [39:0] lo,
                             logic [39:0] hi, bit typed = 1'b0, sweep_res_t fixed = '0);
        sweep_res_t want;
        while ($urandom_range(0, 99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid  <= 1'b1;
        command     <= cmd;
        pin_index   <= pin;
        levels_low  <= lo;
        levels_high <= hi;
        do
            @(posedge clk);
        while (item_stall);
        want = next_sweep_result(cmd, pin, lo, hi);
        if (typed)
            want = fixed;
        pending_results.push_back(want);
        items_sent++;
    endtask

    // Drain the block, then write all five registers one beat each.
    task automatic load_settings(logic [11:0] lo_code, logic [11:0] hi_code,
                                 logic [11:0] step, logic [9:0] reads, logic down);
        logic [CFG_IDX_W-1:0]  idx [5];
        logic [CFG_DATA_W-1:0] val [5];
        idx = '{REG_RAMP_MIN, REG_RAMP_MAX, REG_RAMP_STEP, REG_READS_PER_STEP,
                REG_RAMP_DOWNWARD};
        val = '{lo_code, hi_code, step, {2'b00, reads}, {11'd0, down}};
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            case (idx[i])
                REG_RAMP_MIN:       ramp_cfg.ramp_min       = val[i];
                REG_RAMP_MAX:       ramp_cfg.ramp_max       = val[i];
                REG_RAMP_STEP:      ramp_cfg.ramp_step      = val[i];
                REG_READS_PER_STEP: ramp_cfg.reads_per_step = val[i][COUNT_W-1:0];
                REG_RAMP_DOWNWARD:  ramp_cfg.ramp_downward  = val[i][0];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    // One sweep as a tester would run it: a start, then readings in which each pin
    // turns over at its own point, with a little noise, then a few result reads.
    // Some sweeps are cut short and dropped by the next start.
    task automatic run_sweep();
        logic [79:0]    base;
        logic [79:0]    lv;
        int unsigned    flip_at [NUM_PINS];
        int unsigned    len;
        int unsigned    codes;
        bit             one_pin;
        logic [PIN_W-1:0] target;
        base    = rand_levels();
        one_pin = ($urandom_range(0, 99) < 35);
        target  = PIN_W'($urandom_range(0, NUM_PINS - 1));
        if (ramp_cfg.ramp_step == 0 || ramp_cfg.reads_per_step == 0)
            len = $urandom_range(5, 40);
        else if (ramp_cfg.ramp_min >= ramp_cfg.ramp_max)
            len = $urandom_range(0, 4);
        else
        begin
            codes = (ramp_cfg.ramp_max - ramp_cfg.ramp_min + ramp_cfg.ramp_step - 1)
                    / ramp_cfg.ramp_step;
            len   = codes * ramp_cfg.reads_per_step + $urandom_range(0, 3);
        end
        if (len > MAX_SAMPLES)
            len = MAX_SAMPLES;
        if ($urandom_range(0, 99) < 15)
            len = $urandom_range(0, len);
        for (int p = 0; p < NUM_PINS; p++)
            flip_at[p] = $urandom_range(0, len + len / 3 + 1);

        if (one_pin)
            push_item(CMD_START_ONE, target, base[39:0], base[79:40]);
        else
            push_item(CMD_START_ALL, rand_pin(), base[39:0], base[79:40]);

        for (int unsigned k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 99) < 4)
            begin
                lv = rand_levels();
                push_item(CMD_READ, rand_pin(), lv[39:0], lv[79:40]);
            end
            for (int p = 0; p < NUM_PINS; p++)
                lv[p] = base[p] ^ (k >= flip_at[p]) ^ ($urandom_range(0, 99) < 6);
            push_item(CMD_SAMPLE, rand_pin(), lv[39:0], lv[79:40]);
        end

        repeat ($urandom_range(2, 6))
        begin
            lv = rand_levels();
            push_item(CMD_READ, rand_pin(), lv[39:0], lv[79:40]);
        end
    endtask

    // ---------------------------------------------------------------- result side

    task automatic check_field(string name, logic [11:0] want, logic [11:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Take result beats, check each against the oldest expectation, and choose the
    // next stall: one long hold-off once enough beats have passed, else random.
    always @(posedge clk)
    begin : result_side
        sweep_res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, actual dac_code %h status %h",
                         $time, dac_code, status);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("dac_code", want.dac_code, dac_code);
                check_field("busy_res", 12'(want.busy), 12'(busy_res));
                check_field("sweep_end", 12'(want.ended), 12'(sweep_end));
                check_field("pin_found", 12'(want.found), 12'(pin_found));
                check_field("pin_code", want.code, pin_code);
                check_field("status", 12'(want.status), 12'(status));
            end
        end
        if (hold_left != 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            // Hold off long enough for the block to fill up and push back on its input.
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(0, 99) < recv_idle);
    end

    // Watchdog: give up when neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (res_valid && !res_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    task automatic add_row(logic [1:0] cmd, logic [PIN_W-1:0] pin, logic [39:0] lo,
                           logic [39:0] hi, bit typed = 1'b0, sweep_res_t res = '0);
        dir_row_t row;
        row = '{cmd, pin, lo, hi, typed, res};
        plan.push_back(row);
    endtask

    initial
    begin
        logic [79:0] lv;
        int unsigned target;

        // Directed table, run at the reset register values (downward, 10 reads a code).
        // At rest: reads, an out-of-range read, a sample that must be ignored, and
        // single starts on pins that do not exist.
        add_row(CMD_READ,      7'd0,   '0, '0, 1'b1, REST_OK);
        add_row(CMD_READ,      7'd127, '0, '0, 1'b1, REST_BAD);
        add_row(CMD_SAMPLE,    7'd5,   '1, '1, 1'b1, REST_OK);
        add_row(CMD_START_ONE, 7'd80,  '0, '0, 1'b1, REST_BAD);
        add_row(CMD_START_ONE, 7'd127, '1, '0, 1'b1, REST_BAD);
        // Sweep all pins; every reading differs from the reference, so all pins flip
        // on the sixth beat at the first code, and the tenth moves the ramp on.
        add_row(CMD_START_ALL, 7'd0,   '0, '1, 1'b1, FIRST_CODE);
        add_row(CMD_SAMPLE,    7'd0,   '1, '0);
        add_row(CMD_SAMPLE,    7'd39,  '1, '0);
        add_row(CMD_SAMPLE,    7'd40,  '1, '0);
        add_row(CMD_SAMPLE,    7'd79,  '1, '0);
        add_row(CMD_SAMPLE,    7'd80,  '1, '0);
        add_row(CMD_SAMPLE,    7'd127, '1, '0);
        add_row(CMD_SAMPLE,    7'd0,   '1, '0);
        add_row(CMD_SAMPLE,    7'd1,   '1, '0);
        add_row(CMD_SAMPLE,    7'd2,   '1, '0);
        add_row(CMD_SAMPLE,    7'd3,   '1, '0);
        add_row(CMD_READ,      7'd79,  '0, '0);
        // Restart as a single-pin sweep while busy; only that pin is cleared, and the
        // sweep ends on the beat that finds it.
        add_row(CMD_START_ONE, 7'd40,  40'hAA_AAAA_AAAA, 40'h55_5555_5555);
        add_row(CMD_SAMPLE,    7'd9,   40'h12_3456_789A, '0);
        add_row(CMD_SAMPLE,    7'd99,  '1, '0);
        add_row(CMD_SAMPLE,    7'd40,  '0, '0);
        add_row(CMD_SAMPLE,    7'd41,  '1, '0);
        add_row(CMD_SAMPLE,    7'd0,   '0, '0);
        add_row(CMD_SAMPLE,    7'd127, '1, '0);
        add_row(CMD_READ,      7'd0,   '0, '0);
        add_row(CMD_READ,      7'd40,  '1, '1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 9;
        recv_idle = 46;
        foreach (plan[i])
            push_item(plan[i].cmd, plan[i].pin, plan[i].lo, plan[i].hi, plan[i].typed,
                      plan[i].res);

        // Random phases: first a slow receiver, then a slow sender, then full rate.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph / 3)
                0:       begin send_idle = 9;  recv_idle = 46; end
                1:       begin send_idle = 46; recv_idle = 9;  end
                default: begin send_idle = 0;  recv_idle = 0;  end
            endcase
            load_settings(plan_min[ph], plan_max[ph], plan_step[ph], plan_reads[ph],
                          plan_down[ph]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 99) < 75)
                    run_sweep();
                else
                    repeat ($urandom_range(1, 5))
                    begin
                        lv = rand_levels();
                        push_item(2'($urandom_range(0, 3)), PIN_W'($urandom_range(0, 127)),
                                  lv[39:0], lv[79:40]);
                    end
            end
        end

        // Drop valid, drain, and give stray beats a chance to show.
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
